// ===== design/cpc_pkg.sv =====
package cpc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 20;
    localparam int RAD_W   = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 96;
    localparam int LIMB_W  = 22;
    localparam int WIDE_W  = 2 * LIMB_W - 1;
    localparam int R2_W    = 2 * RAD_W;
    localparam int IN_W    = 4 * COORD_W + 2 * RAD_W;
    localparam int OUT_W   = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [MUL_W-1:0]   mul_op_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef enum logic [1:0] {SH_0, SH_1L, SH_2L} shift_t;

    typedef struct packed {
        logic   mul_en;
        logic   acc_en;
        logic   clr;
        logic   sub;
        shift_t sh;
    } mac_ctl_t;

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_DONE} state_t;

    typedef enum logic [4:0] {
        U_CC_X, U_CC_Y, U_CC_R, U_R2,
        U_AREA_A, U_AREA_B, U_C0_A, U_C0_B, U_C1_A, U_C1_B, U_C2_A, U_C2_B,
        U_VX, U_VY, U_VR,
        U_DD_X, U_DD_Y, U_FD_X, U_FD_Y,
        U_CR_A, U_CR_B,
        U_SQ_LL, U_SQ_HL0, U_SQ_HL1, U_SQ_HH,
        U_RD_L, U_RD_H
    } uop_t;

    function automatic diff_t sub_c(input coord_t a, input coord_t b);
        sub_c = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic mul_op_t ext_d(input diff_t d);
        ext_d = MUL_W'(d);
    endfunction

endpackage

// ===== design/cpc_vmem.sv =====
module cpc_vmem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [cpc_pkg::IDX_W-1:0] waddr,
    input  cpc_pkg::coord_t           wx,
    input  cpc_pkg::coord_t           wy,
    input  logic [cpc_pkg::IDX_W-1:0] raddr,
    output cpc_pkg::coord_t           rx,
    output cpc_pkg::coord_t           ry
);
    import cpc_pkg::*;

    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];
    coord_t rx_reg;
    coord_t ry_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_x[waddr] <= wx;
            mem_y[waddr] <= wy;
        end
        rx_reg <= mem_x[raddr];
        ry_reg <= mem_y[raddr];
    end

    assign rx = rx_reg;
    assign ry = ry_reg;

endmodule

// ===== design/cpc_mac.sv =====
module cpc_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  cpc_pkg::mac_ctl_t ctl,
    input  cpc_pkg::mul_op_t  opa,
    input  cpc_pkg::mul_op_t  opb,
    output cpc_pkg::acc_t     acc_next
);
    import cpc_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     acc_reg;
    acc_t                     term;
    acc_t                     shifted;
    acc_t                     base;

    assign prod = opa * opb;

    always_comb
    begin
        term = ACC_W'(prod_reg);
        unique case (ctl.sh)
            SH_0:    shifted = term;
            SH_1L:   shifted = term <<< LIMB_W;
            SH_2L:   shifted = term <<< (2 * LIMB_W);
            default: shifted = term;
        endcase
        base     = ctl.clr ? '0 : acc_reg;
        acc_next = ctl.sub ? base - shifted : base + shifted;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctl.acc_en)
            acc_reg <= acc_next;
    end

endmodule

// ===== design/circle_polygon_collision.sv =====
// Channel  Dir  tdata                                  tuser     tlast
// s_*      in   circle x/y/r, shape x/y/r (112 bits)   req_type  last_vertex
// m_*      out  hit, vertices_dropped (8 bits)         -         -
//
// A circle query takes three products. A vertex without the last mark is
// only stored and the unit stays idle. A closing vertex takes the r squared
// product and then, for each stored vertex until a hit, a vertex fetch and up to
// 23 products through the shared 33x33 multiply-accumulate, each as a multiply phase then an accumulate phase.
// s_tready is high only when the sequencer is idle; a finished word waits
// in the output register while the next item is taken. Reset clears control.
module circle_polygon_collision (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // circle_x, circle_y, circle_radius, shape_x, shape_y, shape_radius
    input  logic [cpc_pkg::IN_W-1:0]    s_tdata,
    // req_type
    input  logic                        s_tuser,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, vertices_dropped, zero fill
    output logic [cpc_pkg::OUT_W-1:0]   m_tdata
);
    import cpc_pkg::*;

    coord_t            in_cx, in_cy, in_sx, in_sy;
    logic [RAD_W-1:0]  in_cr, in_sr;

    assign in_cx = s_tdata[COORD_W-1:0];
    assign in_cy = s_tdata[2*COORD_W-1:COORD_W];
    assign in_cr = s_tdata[2*COORD_W+RAD_W-1:2*COORD_W];
    assign in_sx = s_tdata[3*COORD_W+RAD_W-1:2*COORD_W+RAD_W];
    assign in_sy = s_tdata[4*COORD_W+RAD_W-1:3*COORD_W+RAD_W];
    assign in_sr = s_tdata[IN_W-1:4*COORD_W+RAD_W];

    state_t            state_reg, state_next;
    uop_t              uop_reg, uop_next;
    logic              ph_reg, ph_next;
    logic [1:0]        fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]  vidx_reg, vidx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic              drop_reg, drop_next;
    logic              hit_reg, hit_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_data_reg;

    coord_t            px_reg, py_reg, x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [RAD_W-1:0]  r_reg;
    logic [RAD_W:0]    rs_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [WIDE_W-1:0] dd_reg, c_reg;
    logic              area_pos_reg, area_neg_reg;
    logic [1:0]        cpos_reg, cneg_reg;

    logic              accept, out_load, mem_we;
    logic [IDX_W-1:0]  raddr;
    logic [CNT_W-1:0]  i1, i2;
    coord_t            rx, ry;
    mac_ctl_t          ctl;
    mul_op_t           opa, opb;
    acc_t              acc_next, acc_abs;
    logic              acc_neg, acc_le0, acc_pos, tri_hit, perp, last_idx;
    diff_t             x10, y10, x20, y20, x21, y21, x02, y02;
    diff_t             px0, py0, px1, py1, px2, py2;

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign x10 = sub_c(x1_reg, x0_reg);
    assign y10 = sub_c(y1_reg, y0_reg);
    assign x20 = sub_c(x2_reg, x0_reg);
    assign y20 = sub_c(y2_reg, y0_reg);
    assign x21 = sub_c(x2_reg, x1_reg);
    assign y21 = sub_c(y2_reg, y1_reg);
    assign x02 = sub_c(x0_reg, x2_reg);
    assign y02 = sub_c(y0_reg, y2_reg);
    assign px0 = sub_c(px_reg, x0_reg);
    assign py0 = sub_c(py_reg, y0_reg);
    assign px1 = sub_c(px_reg, x1_reg);
    assign py1 = sub_c(py_reg, y1_reg);
    assign px2 = sub_c(px_reg, x2_reg);
    assign py2 = sub_c(py_reg, y2_reg);

    assign acc_neg = acc_next[ACC_W-1];
    assign acc_le0 = acc_neg || (acc_next == '0);
    assign acc_pos = !acc_le0;
    assign acc_abs = acc_neg ? -acc_next : acc_next;

    // centre inside when all edge crosses agree with the winding; flat counts as out
    assign tri_hit = area_pos_reg ? !(cneg_reg[0] || cneg_reg[1] || acc_neg) :
                     area_neg_reg ? !(cpos_reg[0] || cpos_reg[1] || acc_pos) : 1'b0;
    // projection falls strictly inside a non-degenerate edge
    assign perp    = (dd_reg != '0) && acc_pos && (acc_next < $signed(ACC_W'(dd_reg)));

    assign i1       = (vidx_reg + CNT_W'(1) == n_reg) ? '0 : vidx_reg + CNT_W'(1);
    assign i2       = (i1 + CNT_W'(1) == n_reg) ? '0 : i1 + CNT_W'(1);
    assign last_idx = (vidx_reg + CNT_W'(1) == n_reg);

    cpc_vmem u_vmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wx    (in_sx),
        .wy    (in_sy),
        .raddr (raddr),
        .rx    (rx),
        .ry    (ry)
    );

    cpc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .opa      (opa),
        .opb      (opb),
        .acc_next (acc_next)
    );

    // operand select and accumulate mode for each micro-op
    always_comb
    begin
        opa        = '0;
        opb        = '0;
        ctl.mul_en = (state_reg == S_EXEC) && !ph_reg;
        ctl.acc_en = (state_reg == S_EXEC) && ph_reg;
        ctl.clr    = 1'b0;
        ctl.sub    = 1'b0;
        ctl.sh     = SH_0;
        unique case (uop_reg)
            U_CC_X:   begin opa = ext_d(px0); opb = ext_d(px0); ctl.clr = 1'b1; end
            U_CC_Y:   begin opa = ext_d(py0); opb = ext_d(py0); end
            U_CC_R:
            begin
                opa = $signed(MUL_W'(rs_reg)); opb = $signed(MUL_W'(rs_reg)); ctl.sub = 1'b1;
            end
            U_R2:
            begin
                opa = $signed(MUL_W'(r_reg)); opb = $signed(MUL_W'(r_reg)); ctl.clr = 1'b1;
            end
            U_AREA_A: begin opa = ext_d(x10); opb = ext_d(y20); ctl.clr = 1'b1; end
            U_AREA_B: begin opa = ext_d(y10); opb = ext_d(x20); ctl.sub = 1'b1; end
            U_C0_A:   begin opa = ext_d(x10); opb = ext_d(py0); ctl.clr = 1'b1; end
            U_C0_B:   begin opa = ext_d(y10); opb = ext_d(px0); ctl.sub = 1'b1; end
            U_C1_A:   begin opa = ext_d(x21); opb = ext_d(py1); ctl.clr = 1'b1; end
            U_C1_B:   begin opa = ext_d(y21); opb = ext_d(px1); ctl.sub = 1'b1; end
            U_C2_A:   begin opa = ext_d(x02); opb = ext_d(py2); ctl.clr = 1'b1; end
            U_C2_B:   begin opa = ext_d(y02); opb = ext_d(px2); ctl.sub = 1'b1; end
            U_VX:     begin opa = ext_d(px0); opb = ext_d(px0); ctl.clr = 1'b1; end
            U_VY:     begin opa = ext_d(py0); opb = ext_d(py0); end
            U_VR:
            begin
                opa = $signed(MUL_W'(r_reg)); opb = $signed(MUL_W'(r_reg)); ctl.sub = 1'b1;
            end
            U_DD_X:   begin opa = ext_d(x10); opb = ext_d(x10); ctl.clr = 1'b1; end
            U_DD_Y:   begin opa = ext_d(y10); opb = ext_d(y10); end
            U_FD_X:   begin opa = ext_d(px0); opb = ext_d(x10); ctl.clr = 1'b1; end
            U_FD_Y:   begin opa = ext_d(py0); opb = ext_d(y10); end
            U_CR_A:   begin opa = ext_d(x10); opb = ext_d(py0); ctl.clr = 1'b1; end
            U_CR_B:   begin opa = ext_d(y10); opb = ext_d(px0); ctl.sub = 1'b1; end
            U_SQ_LL:
            begin
                opa = $signed(MUL_W'(c_reg[LIMB_W-1:0]));
                opb = $signed(MUL_W'(c_reg[LIMB_W-1:0]));
                ctl.clr = 1'b1;
            end
            U_SQ_HL0, U_SQ_HL1:
            begin
                opa = $signed(MUL_W'(c_reg[WIDE_W-1:LIMB_W]));
                opb = $signed(MUL_W'(c_reg[LIMB_W-1:0]));
                ctl.sh = SH_1L;
            end
            U_SQ_HH:
            begin
                opa = $signed(MUL_W'(c_reg[WIDE_W-1:LIMB_W]));
                opb = $signed(MUL_W'(c_reg[WIDE_W-1:LIMB_W]));
                ctl.sh = SH_2L;
            end
            U_RD_L:
            begin
                opa = $signed(MUL_W'(r2_reg));
                opb = $signed(MUL_W'(dd_reg[LIMB_W-1:0]));
                ctl.sub = 1'b1;
            end
            U_RD_H:
            begin
                opa = $signed(MUL_W'(r2_reg));
                opb = $signed(MUL_W'(dd_reg[WIDE_W-1:LIMB_W]));
                ctl.sub = 1'b1;
                ctl.sh = SH_1L;
            end
            default: ;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = (state_reg == S_IDLE);
        mem_we     = (state_reg == S_IDLE) && s_tvalid && s_tuser &&
                     (cnt_reg < CNT_W'(MAX_VERTICES));
        unique case (fcnt_reg)
            2'd0:    raddr = vidx_reg[IDX_W-1:0];
            2'd1:    raddr = i1[IDX_W-1:0];
            default: raddr = i2[IDX_W-1:0];
        endcase
    end

    // next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        ph_next    = ph_reg;
        fcnt_next  = fcnt_reg;
        vidx_next  = vidx_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        drop_next  = drop_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ph_next = 1'b0;
                    if (!s_tuser)
                    begin
                        state_next = S_EXEC;
                        uop_next   = U_CC_X;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        if (cnt_reg < CNT_W'(MAX_VERTICES))
                            cnt_next = cnt_reg + CNT_W'(1);
                        else
                            ovf_next = 1'b1;
                        if (s_tlast)
                        begin
                            n_next     = (cnt_reg < CNT_W'(MAX_VERTICES)) ?
                                         cnt_reg + CNT_W'(1) : cnt_reg;
                            drop_next  = ovf_reg || (cnt_reg == CNT_W'(MAX_VERTICES));
                            cnt_next   = '0;
                            ovf_next   = 1'b0;
                            vidx_next  = '0;
                            state_next = S_EXEC;
                            uop_next   = U_R2;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd3)
                begin
                    state_next = S_EXEC;
                    ph_next    = 1'b0;
                    uop_next   = (n_reg >= CNT_W'(3)) ? U_AREA_A : U_VX;
                end
            end
            S_EXEC:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    unique case (uop_reg)
                        U_CC_X:   uop_next = U_CC_Y;
                        U_CC_Y:   uop_next = U_CC_R;
                        U_CC_R:   begin state_next = S_DONE; hit_next = acc_le0; end
                        U_R2:     begin state_next = S_FETCH; fcnt_next = '0; end
                        U_AREA_A: uop_next = U_AREA_B;
                        U_AREA_B: uop_next = U_C0_A;
                        U_C0_A:   uop_next = U_C0_B;
                        U_C0_B:   uop_next = U_C1_A;
                        U_C1_A:   uop_next = U_C1_B;
                        U_C1_B:   uop_next = U_C2_A;
                        U_C2_A:   uop_next = U_C2_B;
                        U_C2_B:
                        begin
                            if (tri_hit)
                            begin
                                state_next = S_DONE;
                                hit_next   = 1'b1;
                            end
                            else
                                uop_next = U_VX;
                        end
                        U_VX:     uop_next = U_VY;
                        U_VY:     uop_next = U_VR;
                        U_VR:
                        begin
                            if (acc_le0)
                            begin
                                state_next = S_DONE;
                                hit_next   = 1'b1;
                            end
                            else
                                uop_next = U_DD_X;
                        end
                        U_DD_X:   uop_next = U_DD_Y;
                        U_DD_Y:   uop_next = U_FD_X;
                        U_FD_X:   uop_next = U_FD_Y;
                        U_CR_A:   uop_next = U_CR_B;
                        U_CR_B:   uop_next = U_SQ_LL;
                        U_SQ_LL:  uop_next = U_SQ_HL0;
                        U_SQ_HL0: uop_next = U_SQ_HL1;
                        U_SQ_HL1: uop_next = U_SQ_HH;
                        U_SQ_HH:  uop_next = U_RD_L;
                        U_RD_L:   uop_next = U_RD_H;
                        U_FD_Y, U_RD_H:
                        begin
                            if (uop_reg == U_FD_Y && perp)
                                uop_next = U_CR_A;
                            else if (uop_reg == U_RD_H && acc_le0)
                            begin
                                state_next = S_DONE;
                                hit_next   = 1'b1;
                            end
                            else if (last_idx)
                            begin
                                state_next = S_DONE;
                                hit_next   = 1'b0;
                            end
                            else
                            begin
                                // advance to the next vertex
                                vidx_next  = vidx_reg + CNT_W'(1);
                                state_next = S_FETCH;
                                fcnt_next  = '0;
                            end
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            uop_reg     <= U_CC_X;
            ph_reg      <= 1'b0;
            fcnt_reg    <= '0;
            vidx_reg    <= '0;
            n_reg       <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            drop_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            uop_reg     <= uop_next;
            ph_reg      <= ph_next;
            fcnt_reg    <= fcnt_next;
            vidx_reg    <= vidx_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            drop_reg    <= drop_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && !s_tuser)
        begin
            px_reg <= in_cx;
            py_reg <= in_cy;
            x0_reg <= in_sx;
            y0_reg <= in_sy;
            rs_reg <= (RAD_W+1)'(in_cr) + (RAD_W+1)'(in_sr);
        end
        if (accept && s_tuser && s_tlast)
        begin
            px_reg <= in_cx;
            py_reg <= in_cy;
            r_reg  <= in_cr;
        end
        if (state_reg == S_FETCH)
        begin
            unique case (fcnt_reg)
                2'd1:    begin x0_reg <= rx; y0_reg <= ry; end
                2'd2:    begin x1_reg <= rx; y1_reg <= ry; end
                2'd3:    begin x2_reg <= rx; y2_reg <= ry; end
                default: ;
            endcase
        end
        if (state_reg == S_EXEC && ph_reg)
        begin
            unique case (uop_reg)
                U_R2:    r2_reg <= acc_next[R2_W-1:0];
                U_AREA_B:
                begin
                    area_pos_reg <= acc_pos;
                    area_neg_reg <= acc_neg;
                end
                U_C0_B:  begin cpos_reg[0] <= acc_pos; cneg_reg[0] <= acc_neg; end
                U_C1_B:  begin cpos_reg[1] <= acc_pos; cneg_reg[1] <= acc_neg; end
                U_DD_Y:  dd_reg <= acc_next[WIDE_W-1:0];
                U_CR_B:  c_reg <= acc_abs[WIDE_W-1:0];
                default: ;
            endcase
        end
        if (out_load)
            m_data_reg <= {drop_reg, hit_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W-2){1'b0}}, m_data_reg};

endmodule

// ===== design/cpc_checker.sv =====
module cpc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      s_tuser,
    input logic                      s_tlast,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [cpc_pkg::OUT_W-1:0] m_tdata
);
    import cpc_pkg::*;

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:2] == '0)
        else $error("output padding not zero");

    a_circ_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("circle query did not occupy the unit");

    a_open_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !s_tlast |=> s_tready && !$rose(m_tvalid))
        else $error("open vertex stalled input or produced a word");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared in the cycle after acceptance");

endmodule

bind circle_polygon_collision cpc_checker u_cpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
